/* rtl/core/gabp_pkg.sv */
// Shared types, register indexes and helpers for the glyph atlas box placer.
package gabp_pkg;

  localparam int unsigned EdgeW  = 13;
  localparam int unsigned GapW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [EdgeW-1:0] EdgeMax = 13'd8191;

  localparam logic [CfgIdxW-1:0] CfgAtlasWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAtlasHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGap         = 2'd2;

  typedef struct packed {
    logic             start_new;
    logic [EdgeW-1:0] glyph_width;
    logic [EdgeW-1:0] glyph_height;
  } gabp_in_t;

  typedef struct packed {
    logic [EdgeW-1:0] box_left;
    logic [EdgeW-1:0] box_top;
    logic [EdgeW-1:0] box_right;
    logic [EdgeW-1:0] box_bottom;
    logic             overflow;
  } gabp_out_t;

  // Candidate box travelling down the cell row. Edges are exact, not saturated.
  typedef struct packed {
    logic [EdgeW-1:0] left;
    logic [EdgeW:0]   right;
    logic [EdgeW:0]   top;
  } gabp_tok_t;

  // One stored box, saturated edges.
  typedef struct packed {
    logic [EdgeW-1:0] left;
    logic [EdgeW-1:0] right;
    logic [EdgeW-1:0] bottom;
  } gabp_entry_t;

  typedef enum logic [1:0] {
    GABP_IDLE,
    GABP_RUN,
    GABP_FIN
  } gabp_state_e;

  function automatic logic [EdgeW-1:0] sat13(input logic [EdgeW+1:0] v);
    sat13 = (v > {2'b00, EdgeMax}) ? EdgeMax : v[EdgeW-1:0];
  endfunction

endpackage

/* rtl/core/glyph_atlas_box_placer.sv */
// Top level of the glyph atlas box placer: control, configuration and the cell row.
//
// Each glyph transfer places one box and returns it once the output register is free;
// the candidate box walks the row of MAX_GLYPHS cells, one cell per cycle, each cell
// able to hold one earlier box, and the next glyph is taken only after the result has
// entered the output register. A result still stalled in the output register holds the
// finish step and delays both the new result and the next glyph by the length of that
// stall. A start_new transfer returns nothing. A finished result sits in an output
// register, so the next glyph may be accepted while it waits. The cursor starts at 0
// after reset and at the gap after start_new.
module glyph_atlas_box_placer #(
  parameter int unsigned MAX_GLYPHS = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gabp_pkg::gabp_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gabp_pkg::gabp_out_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [12:0]          cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_GLYPHS + 1);

  gabp_pkg::gabp_state_e state_q, state_d;

  logic [12:0]     width_q, height_q;
  logic [7:0]      gap_q;
  logic [CntW-1:0] cnt_q;
  logic [12:0]     cursor_q;
  logic [12:0]     left_q, w_q, h_q;
  logic [13:0]     right_q, top_q;
  logic            out_valid_q;
  gabp_pkg::gabp_out_t out_q;

  logic        accept, launch, slot_free, finish, full, store_wr;
  logic [14:0] wrap_sum;
  logic [12:0] left_new;
  logic [14:0] bottom, cursor_sum;
  logic        over;

  logic                  tok_vld [MAX_GLYPHS+1];
  gabp_pkg::gabp_tok_t   tok     [MAX_GLYPHS+1];
  logic [CntW-1:0]       rem     [MAX_GLYPHS+1];
  logic [MAX_GLYPHS-1:0] wr_en;
  gabp_pkg::gabp_entry_t wr_entry;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != gabp_pkg::GABP_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign launch      = accept && !in_data_i.start_new;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign full        = (cnt_q == CntW'(MAX_GLYPHS));

  // The left edge wraps back to the gap when the box plus spacing would pass the width.
  assign wrap_sum = {2'b00, cursor_q} + {2'b00, in_data_i.glyph_width} + {7'd0, gap_q};
  assign left_new = (wrap_sum > {2'b00, width_q}) ? {5'd0, gap_q} : cursor_q;

  assign bottom     = {1'b0, top_q} + {2'b00, h_q};
  assign cursor_sum = {2'b00, left_q} + {2'b00, w_q} + {7'd0, gap_q};
  assign over       = full || (bottom > {2'b00, height_q}) ||
                      ({1'b0, right_q} > {2'b00, width_q});

  always_comb begin
    state_d = state_q;
    finish  = 1'b0;
    unique case (state_q)
      gabp_pkg::GABP_IDLE: begin
        if (launch) begin
          state_d = gabp_pkg::GABP_RUN;
        end
      end
      gabp_pkg::GABP_RUN: begin
        if (tok_vld[MAX_GLYPHS]) begin
          state_d = gabp_pkg::GABP_FIN;
        end
      end
      gabp_pkg::GABP_FIN: begin
        if (slot_free) begin
          finish  = 1'b1;
          state_d = gabp_pkg::GABP_IDLE;
        end
      end
      default: begin
        state_d = gabp_pkg::GABP_IDLE;
      end
    endcase
  end

  assign store_wr = finish && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gabp_pkg::GABP_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 13'd1024;
      height_q    <= 13'd1024;
      gap_q       <= 8'd1;
      cnt_q       <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          gabp_pkg::CfgAtlasWidth:  width_q  <= cfg_data_i;
          gabp_pkg::CfgAtlasHeight: height_q <= cfg_data_i;
          gabp_pkg::CfgGap:         gap_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (accept && in_data_i.start_new) begin
        cnt_q    <= '0;
        cursor_q <= {5'd0, gap_q};
      end
      if (store_wr) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (finish) begin
        cursor_q <= gabp_pkg::sat13(cursor_sum);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      left_q  <= left_new;
      right_q <= {1'b0, left_new} + {1'b0, in_data_i.glyph_width};
      w_q     <= in_data_i.glyph_width;
      h_q     <= in_data_i.glyph_height;
    end
    if (state_q == gabp_pkg::GABP_RUN && tok_vld[MAX_GLYPHS]) begin
      top_q <= tok[MAX_GLYPHS].top;
    end
    if (finish) begin
      out_q.box_left   <= left_q;
      out_q.box_top    <= gabp_pkg::sat13({1'b0, top_q});
      out_q.box_right  <= gabp_pkg::sat13({1'b0, right_q});
      out_q.box_bottom <= gabp_pkg::sat13(bottom);
      out_q.overflow   <= over;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The candidate enters the row with its top at the gap and the box count as its budget.
  assign tok_vld[0]   = launch;
  assign tok[0].left  = left_new;
  assign tok[0].right = {1'b0, left_new} + {1'b0, in_data_i.glyph_width};
  assign tok[0].top   = {6'd0, gap_q};
  assign rem[0]       = cnt_q;

  assign wr_entry.left   = left_q;
  assign wr_entry.right  = gabp_pkg::sat13({1'b0, right_q});
  assign wr_entry.bottom = gabp_pkg::sat13(bottom);

  for (genvar i = 0; i < MAX_GLYPHS; i++) begin : g_cell
    assign wr_en[i] = store_wr && (cnt_q == CntW'(i));

    gabp_cell #(
      .CntW(CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .gap_i       (gap_q),
      .tok_valid_i (tok_vld[i]),
      .tok_i       (tok[i]),
      .rem_i       (rem[i]),
      .tok_valid_o (tok_vld[i+1]),
      .tok_o       (tok[i+1]),
      .rem_o       (rem[i+1]),
      .wr_en_i     (wr_en[i]),
      .wr_entry_i  (wr_entry)
    );
  end

  // A candidate leaves the row only while the controller is waiting for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_vld[MAX_GLYPHS] |-> (state_q == gabp_pkg::GABP_RUN))
    else $error("candidate left the cell row outside the run state");

  // At most one cell is written, and only while the store has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr_en))
    else $error("more than one cell written at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en != '0) |-> (cnt_q < CntW'(MAX_GLYPHS)))
    else $error("store written while full");

  // A new result only appears right after the finish state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == gabp_pkg::GABP_FIN))
    else $error("result raised outside the finish state");

endmodule

/* rtl/core/gabp_cell.sv */
// One cell of the box row: holds a stored box and checks the passing candidate against it.
module gabp_cell #(
  parameter int unsigned CntW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           gap_i,
  input  logic                 tok_valid_i,
  input  gabp_pkg::gabp_tok_t  tok_i,
  input  logic [CntW-1:0]      rem_i,
  output logic                 tok_valid_o,
  output gabp_pkg::gabp_tok_t  tok_o,
  output logic [CntW-1:0]      rem_o,
  input  logic                 wr_en_i,
  input  gabp_pkg::gabp_entry_t wr_entry_i
);

  gabp_pkg::gabp_entry_t entry_q;
  gabp_pkg::gabp_tok_t   tok_q, tok_d;
  logic                  vld_q;
  logic [CntW-1:0]       rem_q, rem_d;

  logic        active, hit;
  logic [14:0] left_x, right_x, left_g, right_g, cl_x, cr_g;
  logic [13:0] cb_g;

  // The remaining count tells whether this cell holds one of the stored boxes.
  assign active  = tok_valid_i && (rem_i != '0);

  assign left_x  = {2'b00, tok_i.left};
  assign right_x = {1'b0, tok_i.right};
  assign left_g  = left_x + {7'd0, gap_i};
  assign right_g = right_x + {7'd0, gap_i};
  assign cl_x    = {2'b00, entry_q.left};
  assign cr_g    = {2'b00, entry_q.right} + {7'd0, gap_i};
  assign cb_g    = {1'b0, entry_q.bottom} + {6'd0, gap_i};

  // Subtractions of the gap are moved to the other side so nothing goes negative.
  assign hit = ((left_x < cr_g) && (left_g >= cl_x)) ||
               ((right_x <= cr_g) && (right_g > cl_x)) ||
               ((left_g <= cl_x) && (right_x >= cr_g));

  always_comb begin
    tok_d = tok_i;
    rem_d = rem_i;
    if (active) begin
      rem_d = rem_i - CntW'(1);
      if (hit && (tok_i.top < cb_g)) begin
        tok_d.top = cb_g;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    rem_q <= rem_d;
    if (wr_en_i) begin
      entry_q <= wr_entry_i;
    end
  end

  assign tok_valid_o = vld_q;
  assign tok_o       = tok_q;
  assign rem_o       = rem_q;

endmodule
